// ----- rtl/sasc_pkg.sv -----
// ----------------------------------------------------------------------------
// sasc_pkg
// Types and constants shared by the serial converter scan controller.
// ----------------------------------------------------------------------------
package sasc_pkg;

    localparam int OPCODE_W = 2;
    localparam int SLOT_W   = 3;
    localparam int VALUE_W  = 18;
    localparam int FILTER_W = 8;
    localparam int RANGE_W  = 4;
    localparam int ORDER_W  = 24;
    localparam int LENGTH_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SHIFT_W  = 24;
    localparam int BITCNT_W = 5;
    localparam int PROD_W   = 34;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_INIT = 2'd1,
        OP_CAL  = 2'd2,
        OP_SPARE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_INIT = 2'd1,
        REQ_CAL  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER = 2'd0,
        CFG_RANGE  = 2'd1,
        CFG_ORDER  = 2'd2,
        CFG_LENGTH = 2'd3
    } cfg_idx_t;

    typedef enum logic [10:0] {
        PH_IDLE        = 11'b000_0000_0001,
        PH_W_FILTER    = 11'b000_0000_0010,
        PH_W_MODE_RUN  = 11'b000_0000_0100,
        PH_W_CTRL_SCAN = 11'b000_0000_1000,
        PH_READ        = 11'b000_0001_0000,
        PH_W_CTRL_CAL  = 11'b000_0010_0000,
        PH_W_ZERO      = 11'b000_0100_0000,
        PH_WAIT_ZERO   = 11'b000_1000_0000,
        PH_W_FULL      = 11'b001_0000_0000,
        PH_WAIT_FULL   = 11'b010_0000_0000,
        PH_W_MODE_END  = 11'b100_0000_0000
    } phase_t;

    // converter register addresses / comm bytes
    localparam logic [7:0] COMM_MODE   = 8'h01;
    localparam logic [7:0] COMM_CTRL   = 8'h02;
    localparam logic [7:0] COMM_FILTER = 8'h03;
    localparam logic [7:0] COMM_READ   = 8'h44;

    localparam logic [7:0] MODE_RUN  = 8'd3;
    localparam logic [7:0] MODE_ZERO = 8'd4;
    localparam logic [7:0] MODE_FULL = 8'd5;

    localparam logic [SLOT_W-1:0] CHANNEL_LAST = 3'd7;
    localparam logic [BITCNT_W-1:0] BYTE_BITS = 5'd8;

    // 10 uV scaling: (raw * 1000 + 2^15) >> 16
    localparam logic [PROD_W-1:0] SCALE_MUL   = 34'd1000;
    localparam logic [PROD_W-1:0] SCALE_ROUND = 34'd32768;
    localparam int SCALE_SHIFT = 16;

    localparam logic [FILTER_W-1:0] FILTER_RESET = 8'd82;
    localparam logic [RANGE_W-1:0]  RANGE_RESET  = 4'd15;
    localparam logic [ORDER_W-1:0]  ORDER_RESET  = 24'd11641406;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd8;

    function automatic logic [7:0] comm_byte(input phase_t ph);
        logic [7:0] b;
        case (ph)
            PH_W_FILTER:                  b = COMM_FILTER;
            PH_W_CTRL_SCAN, PH_W_CTRL_CAL: b = COMM_CTRL;
            PH_READ:                      b = COMM_READ;
            default:                      b = COMM_MODE;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/sasc_in_if.sv -----
// ----------------------------------------------------------------------------
// sasc_in_if
// Tick channel: opcode and sampled converter pins.
// ----------------------------------------------------------------------------
interface sasc_in_if
    import sasc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic                ready_n;
    logic                data_out_pin;

    modport source (output valid, output opcode, output ready_n, output data_out_pin,
                    input ready);
    modport sink   (input valid, input opcode, input ready_n, input data_out_pin,
                    output ready);
endinterface

// ----- rtl/sasc_out_if.sv -----
// ----------------------------------------------------------------------------
// sasc_out_if
// Result channel: bus levels, sample report and status.
// ----------------------------------------------------------------------------
interface sasc_out_if
    import sasc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               chip_select_n;
    logic               serial_clock;
    logic               data_in_pin;
    logic               sample_valid;
    logic [SLOT_W-1:0]  sample_slot;
    logic [VALUE_W-1:0] sample_value;
    logic               busy_res;
    logic               calibrating;

    modport source (output valid, output chip_select_n, output serial_clock,
                    output data_in_pin, output sample_valid, output sample_slot,
                    output sample_value, output busy_res, output calibrating,
                    input ready);
    modport sink   (input valid, input chip_select_n, input serial_clock,
                    input data_in_pin, input sample_valid, input sample_slot,
                    input sample_value, input busy_res, input calibrating,
                    output ready);
endinterface

// ----- rtl/spi_adc_scan_controller.sv -----
// ----------------------------------------------------------------------------
// spi_adc_scan_controller
// Half-bit sequencer for a serial sigma-delta converter: init, scan, calibrate.
//
//  channel | dir | payload
//  cmd     | in  | opcode, ready_n, data_out_pin
//  rsp     | out | chip_select_n, serial_clock, data_in_pin, sample_valid,
//          |     | sample_slot, sample_value, busy_res, calibrating
//  cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One transaction per clock sustained while rsp is not stalled; a command passes the input register,
// then the sequencer step, scaling multiply and result register.
// Reset starts the init sequence; registers return to their defaults.
// A stalled rsp holds the result register; cmd stays ready while the input
// register is empty or drains into the result register.
// ----------------------------------------------------------------------------
module spi_adc_scan_controller
    import sasc_pkg::*;
#(
    parameter int SLOT_COUNT  = 8,
    parameter int SAMPLE_BITS = 24
)(
    input  logic                  clk,
    input  logic                  rst_n,
    sasc_in_if.sink               cmd,
    sasc_out_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [LENGTH_W-1:0] SLOTS_MAX = LENGTH_W'(SLOT_COUNT);
    localparam logic [BITCNT_W-1:0] READ_BITS = BITCNT_W'(SAMPLE_BITS);
    localparam int RAW_SHIFT = SHIFT_W - SAMPLE_BITS;

    // configuration
    logic [FILTER_W-1:0] filter_reg;
    logic [RANGE_W-1:0]  range_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [LENGTH_W-1:0] length_reg;

    // input register
    logic                in_vld_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic                rdy_n_reg;
    logic                dout_reg;

    // sequencer state
    phase_t              phase_reg, phase_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   calch_reg, calch_next;
    req_t                pend_reg, pend_next;
    logic                frame_reg, frame_next;
    logic                sck_reg, sck_next;

    // result register
    logic                out_vld_reg;
    logic                cs_reg, cs_next;
    logic                sclk_reg, sclk_next;
    logic                din_reg, din_next;
    logic                sv_reg, sv_next;
    logic [SLOT_W-1:0]   sslot_reg, sslot_next;
    logic [VALUE_W-1:0]  sval_reg, sval_next;
    logic                busy_reg, busy_next;
    logic                cal_reg, cal_next;

    logic                advance;
    logic [SHIFT_W-1:0]  raw24;
    logic [PROD_W-1:0]   scaled;
    logic [LENGTH_W-1:0] scan_len;

    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign cmd.ready = !in_vld_reg || advance;

    assign raw24  = SHIFT_W'(shift_reg[SAMPLE_BITS-1:0]) << RAW_SHIFT;
    assign scaled = (PROD_W'(raw24) * SCALE_MUL + SCALE_ROUND) >> SCALE_SHIFT;

    always_comb
    begin
        if (length_reg == '0)
            scan_len = LENGTH_W'(1);
        else if (length_reg > SLOTS_MAX)
            scan_len = SLOTS_MAX;
        else
            scan_len = length_reg;
    end

    always_comb
    begin
        logic                reading;
        logic [BITCNT_W-1:0] nbits;
        logic [7:0]          word;
        logic [SLOT_W-1:0]   scan_ch;
        logic [LENGTH_W-1:0] slot_inc;

        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        shift_next  = shift_reg;
        slot_next   = slot_reg;
        calch_next  = calch_reg;
        frame_next  = frame_reg;
        sck_next    = sck_reg;
        pend_next   = pend_reg;

        cs_next    = 1'b1;
        sclk_next  = 1'b1;
        din_next   = 1'b0;
        sv_next    = 1'b0;
        sslot_next = '0;
        sval_next  = '0;

        reading  = (phase_reg == PH_READ) && frame_reg;
        nbits    = reading ? READ_BITS : BYTE_BITS;
        word     = frame_reg ? shift_reg[7:0] : comm_byte(phase_reg);
        scan_ch  = order_reg[SLOT_W*slot_reg +: SLOT_W];
        slot_inc = LENGTH_W'(slot_reg) + LENGTH_W'(1);

        if (op_reg == OP_INIT)
            pend_next = REQ_INIT;
        else if (op_reg == OP_CAL)
            pend_next = REQ_CAL;

        case (phase_reg)
            PH_IDLE:
            begin
                bitcnt_next = '0;
                frame_next  = 1'b0;
                sck_next    = 1'b0;
                if (pend_next == REQ_INIT)
                    phase_next = PH_W_FILTER;
                else if (pend_next == REQ_CAL)
                begin
                    calch_next = '0;
                    phase_next = PH_W_CTRL_CAL;
                end
                else if (!rdy_n_reg)
                    phase_next = PH_READ;
                pend_next = REQ_NONE;
            end
            PH_WAIT_ZERO:
            begin
                if (!rdy_n_reg)
                    phase_next = PH_W_FULL;
            end
            PH_WAIT_FULL:
            begin
                if (!rdy_n_reg)
                begin
                    if (calch_reg == CHANNEL_LAST)
                        phase_next = PH_W_MODE_END;
                    else
                    begin
                        calch_next = calch_reg + SLOT_W'(1);
                        phase_next = PH_W_CTRL_CAL;
                    end
                end
            end
            PH_W_FILTER, PH_W_MODE_RUN, PH_W_CTRL_SCAN, PH_READ,
            PH_W_CTRL_CAL, PH_W_ZERO, PH_W_FULL, PH_W_MODE_END:
            begin
                if (bitcnt_reg < nbits)
                begin
                    cs_next   = 1'b0;
                    sclk_next = sck_reg;
                    din_next  = reading ? 1'b0 : word[~bitcnt_reg[2:0]];
                    if (!sck_reg)
                    begin
                        if (reading)
                            shift_next = {shift_reg[SHIFT_W-2:0], dout_reg};
                        sck_next = 1'b1;
                    end
                    else
                    begin
                        sck_next    = 1'b0;
                        bitcnt_next = bitcnt_reg + BITCNT_W'(1);
                    end
                end
                else
                begin
                    bitcnt_next = '0;
                    sck_next    = 1'b0;
                    if (!frame_reg)
                    begin
                        frame_next = 1'b1;
                        case (phase_reg)
                            PH_W_FILTER:    shift_next = SHIFT_W'(filter_reg);
                            PH_W_CTRL_SCAN: shift_next = SHIFT_W'({1'b0, scan_ch, range_reg});
                            PH_W_CTRL_CAL:  shift_next = SHIFT_W'({1'b0, calch_reg, range_reg});
                            PH_W_ZERO:      shift_next = SHIFT_W'(MODE_ZERO);
                            PH_W_FULL:      shift_next = SHIFT_W'(MODE_FULL);
                            PH_READ:        shift_next = '0;
                            default:        shift_next = SHIFT_W'(MODE_RUN);
                        endcase
                    end
                    else
                    begin
                        frame_next = 1'b0;
                        case (phase_reg)
                            PH_W_FILTER:   phase_next = PH_W_MODE_RUN;
                            PH_W_MODE_RUN: phase_next = PH_W_CTRL_SCAN;
                            PH_READ:
                            begin
                                sv_next    = 1'b1;
                                sslot_next = slot_reg;
                                sval_next  = scaled[VALUE_W-1:0];
                                slot_next  = (slot_inc >= scan_len) ? '0 : slot_inc[SLOT_W-1:0];
                                phase_next = PH_W_CTRL_SCAN;
                            end
                            PH_W_CTRL_CAL: phase_next = PH_W_ZERO;
                            PH_W_ZERO:     phase_next = PH_WAIT_ZERO;
                            PH_W_FULL:     phase_next = PH_WAIT_FULL;
                            default:       phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                bitcnt_next = '0;
                frame_next  = 1'b0;
                sck_next    = 1'b0;
            end
        endcase

        busy_next = (phase_next != PH_IDLE) || (pend_next != REQ_NONE);
        cal_next  = (phase_next == PH_W_CTRL_CAL) || (phase_next == PH_W_ZERO)
                 || (phase_next == PH_WAIT_ZERO) || (phase_next == PH_W_FULL)
                 || (phase_next == PH_WAIT_FULL) || (phase_next == PH_W_MODE_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= FILTER_RESET;
            range_reg  <= RANGE_RESET;
            order_reg  <= ORDER_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FILTER: filter_reg <= cfg_wdata[FILTER_W-1:0];
                CFG_RANGE:  range_reg  <= cfg_wdata[RANGE_W-1:0];
                CFG_ORDER:  order_reg  <= cfg_wdata[ORDER_W-1:0];
                CFG_LENGTH: length_reg <= cfg_wdata[LENGTH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (cmd.ready)
            in_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            op_reg    <= cmd.opcode;
            rdy_n_reg <= cmd.ready_n;
            dout_reg  <= cmd.data_out_pin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_W_FILTER;
            bitcnt_reg <= '0;
            shift_reg  <= '0;
            slot_reg   <= '0;
            calch_reg  <= '0;
            pend_reg   <= REQ_NONE;
            frame_reg  <= 1'b0;
            sck_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            bitcnt_reg <= bitcnt_next;
            shift_reg  <= shift_next;
            slot_reg   <= slot_next;
            calch_reg  <= calch_next;
            pend_reg   <= pend_next;
            frame_reg  <= frame_next;
            sck_reg    <= sck_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (rsp.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cs_reg    <= cs_next;
            sclk_reg  <= sclk_next;
            din_reg   <= din_next;
            sv_reg    <= sv_next;
            sslot_reg <= sslot_next;
            sval_reg  <= sval_next;
            busy_reg  <= busy_next;
            cal_reg   <= cal_next;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.chip_select_n = cs_reg;
    assign rsp.serial_clock  = sclk_reg;
    assign rsp.data_in_pin   = din_reg;
    assign rsp.sample_valid  = sv_reg;
    assign rsp.sample_slot   = sslot_reg;
    assign rsp.sample_value  = sval_reg;
    assign rsp.busy_res      = busy_reg;
    assign rsp.calibrating   = cal_reg;

    // a reported sample always leaves the control write pending
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.sample_valid) |-> (rsp.busy_res && !rsp.calibrating))
        else $error("sample reported without control rewrite pending");

    a_cal_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.calibrating) |-> rsp.busy_res)
        else $error("calibrating while not busy");

    // deselected bus parks clock high and data low
    a_bus_park: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.chip_select_n) |-> (rsp.serial_clock && !rsp.data_in_pin))
        else $error("bus not parked while deselected");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.sample_valid) |-> (rsp.sample_value <= VALUE_W'(256000)))
        else $error("sample value out of range");

    // input register drains into result register whenever the result side is free
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("input register did not drain");

endmodule
